// ----- rtl/bitmap_run_allocator_core_macros.svh -----
// assertion macros for the bitmap run allocator
`ifndef BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bra_pkg.sv -----
// shared types and constants for the bitmap run allocator
`timescale 1ns / 1ps

package bra_pkg;

    // word held by one cell of the ring
    localparam int WORD_W    = 32;
    localparam int WORD_BITS = 5;

    localparam int MAX_BITS_DEF = 1024;

    localparam int TYPE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int COUNT_W = 11;
    // index plus count
    localparam int SUM_W   = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] BITS_IN_USE_RST = 11'd1024;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_SET   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_TEST  = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_FILL  = 2'd3;

    // status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_NO_RUN = 1'b1;

    typedef struct packed {
        logic [TYPE_W-1:0]  req_type;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] count;
        logic               bit_value;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [INDEX_W-1:0] start_index;
        logic               bit_read;
    } rsp_t;

    // controls from the sequencer to the word unit
    typedef struct packed {
        logic wr_en;
        logic wr_value;
        logic scan_value;
    } wu_ctrl_t;

endpackage

// ----- rtl/bra_cell.sv -----
// one ring cell holding a word of the bit map
`timescale 1ns / 1ps

module bra_cell
    import bra_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic [WORD_W-1:0] word_d,
    output logic [WORD_W-1:0] word_q
);

    logic [WORD_W-1:0] word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else if (shift_en)
        begin
            word_reg <= word_d;
        end
    end

    assign word_q = word_reg;

endmodule

// ----- rtl/bra_word_unit.sv -----
// word unit at the ring head: range write and run scan over one word
`timescale 1ns / 1ps

module bra_word_unit
    import bra_pkg::*;
#(
    parameter int CMP_W = SUM_W
)
(
    input  logic [WORD_W-1:0] word_in,
    input  logic [CMP_W-1:0]  base,
    input  logic [CMP_W-1:0]  live,
    input  logic [CMP_W-1:0]  lo,
    input  logic [CMP_W-1:0]  hi,
    input  logic [CMP_W-1:0]  run_in,
    input  logic [CMP_W-1:0]  len,
    input  wu_ctrl_t          ctrl,
    output logic [WORD_W-1:0] word_out,
    output logic [CMP_W-1:0]  run_out,
    output logic              hit,
    output logic [CMP_W-1:0]  hit_start
);

    logic [WORD_W-1:0]    mask;
    logic [WORD_W-1:0]    match;
    logic [WORD_W-1:0]    hits;
    logic [CMP_W-1:0]     lo_rel;
    logic [CMP_W-1:0]     hi_rel;
    logic [WORD_BITS:0]   lo_c;
    logic [WORD_BITS:0]   hi_c;
    logic [WORD_BITS-1:0] hit_pos;
    // position plus one of the last mismatch at or below each bit, zero if none
    logic [WORD_BITS:0]   lz [WORD_BITS+1][WORD_W];
    logic [CMP_W-1:0]     run_len [WORD_W];

    // write mask for [lo, hi) clipped to this word
    always_comb
    begin
        lo_rel = lo - base;
        hi_rel = hi - base;
        if (lo <= base)
            lo_c = '0;
        else if (lo_rel >= CMP_W'(WORD_W))
            lo_c = (WORD_BITS+1)'(WORD_W);
        else
            lo_c = lo_rel[WORD_BITS:0];
        if (hi <= base)
            hi_c = '0;
        else if (hi_rel >= CMP_W'(WORD_W))
            hi_c = (WORD_BITS+1)'(WORD_W);
        else
            hi_c = hi_rel[WORD_BITS:0];
        for (int b = 0; b < WORD_W; b++)
        begin
            mask[b] = ((WORD_BITS+1)'(b) >= lo_c) && ((WORD_BITS+1)'(b) < hi_c);
        end
        if (ctrl.wr_en)
            word_out = (word_in & ~mask) | (ctrl.wr_value ? mask : '0);
        else
            word_out = word_in;
    end

    // run scan: prefix search for the last mismatch, then run length per bit
    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
        begin
            match[b] = (word_in[b] == ctrl.scan_value) && ((base + CMP_W'(b)) < live);
            lz[0][b] = match[b] ? '0 : (WORD_BITS+1)'(b + 1);
        end
        for (int d = 0; d < WORD_BITS; d++)
        begin
            for (int b = 0; b < WORD_W; b++)
            begin
                if ((b >= (1 << d)) && (lz[d][b] == '0))
                    lz[d+1][b] = lz[d][(b >= (1 << d)) ? (b - (1 << d)) : b];
                else
                    lz[d+1][b] = lz[d][b];
            end
        end
        for (int b = 0; b < WORD_W; b++)
        begin
            if (lz[WORD_BITS][b] == '0)
                run_len[b] = run_in + CMP_W'(b + 1);
            else
                run_len[b] = CMP_W'(b + 1) - CMP_W'(lz[WORD_BITS][b]);
            hits[b] = (run_len[b] >= len);
        end
        // lowest bit that completes a run
        hit_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (hits[b])
                hit_pos = WORD_BITS'(b);
        end
        hit       = |hits;
        hit_start = base + CMP_W'(hit_pos) + CMP_W'(1) - len;
        run_out   = run_len[WORD_W-1];
    end

endmodule

// ----- rtl/bitmap_run_allocator_core.sv -----
// bitmap_run_allocator_core: first-fit bit map allocator on a rotating ring of word cells
// passes: set, test, fill and a missed allocate make one ring pass before the result, an
// allocate that finds a run makes two (NCELL = MAX_BITS / 32 rounded up, 32 cells)
// requests: one at a time, the next one taken only after one full ring rotation per map
// pass plus result hand-off, which waits while the result register is stalled
// reset: async active low, map cleared to zero, bits_in_use back to 1024, no result pending
`timescale 1ns / 1ps

`include "bitmap_run_allocator_core_macros.svh"

module bitmap_run_allocator_core
    import bra_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // request channel
    input  logic               req_valid,
    output logic               req_stall,
    input  req_t               req_data,
    // result channel
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output rsp_t               rsp_data,
    // configuration write, bits_in_use
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    // ring geometry
    localparam int NCELL = (MAX_BITS + WORD_W - 1) / WORD_W;
    localparam int CNT_W = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int POS_W = $clog2(NCELL * WORD_W + 1);
    localparam int CMP_W = (POS_W > SUM_W) ? POS_W : SUM_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   word_cnt_reg;
    logic [TYPE_W-1:0]  op_reg;
    logic               value_reg;
    logic               wr_en_reg;
    logic               test_ok_reg;
    logic               found_reg;
    logic [CMP_W-1:0]   lo_reg;
    logic [CMP_W-1:0]   hi_reg;
    logic [CMP_W-1:0]   len_reg;
    logic [CMP_W-1:0]   run_reg;
    logic [CMP_W-1:0]   start_reg;
    logic [COUNT_W-1:0] bits_in_use_reg;
    rsp_t               res_reg;
    rsp_t               rsp_reg;
    logic               rsp_valid_reg;

    // ring wiring: cell 0 is the head, the word unit feeds the tail
    logic [WORD_W-1:0]  cell_q [NCELL];
    logic [WORD_W-1:0]  head_word;
    logic [WORD_W-1:0]  unit_word;
    logic               shift_en;

    logic [CMP_W-1:0]   base;
    logic [CMP_W-1:0]   live;
    logic [CMP_W-1:0]   biu_ext;
    logic [CMP_W-1:0]   set_sum;
    logic [CMP_W-1:0]   set_hi;
    logic [CMP_W-1:0]   run_out;
    logic [CMP_W-1:0]   hit_start;
    logic [CMP_W-1:0]   start_now;
    logic               unit_hit;
    logic               scan_hit;
    logic               found_now;
    logic               last_word;
    logic               test_here;
    logic               out_free;
    wu_ctrl_t           unit_ctrl;

    // the ring turns only while a pass runs, one word per cycle
    assign shift_en  = (state_reg == ST_SCAN) || (state_reg == ST_WRITE);
    assign head_word = cell_q[0];

    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++)
        begin : g_ring
            if (gi == NCELL - 1)
            begin : g_tail
                bra_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .word_d   (unit_word),
                    .word_q   (cell_q[gi])
                );
            end
            else
            begin : g_body
                bra_cell u_cell
                (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .word_d   (cell_q[gi+1]),
                    .word_q   (cell_q[gi])
                );
            end
        end
    endgenerate

    // live bits, clipped to the map size
    assign biu_ext = CMP_W'(bits_in_use_reg);
    assign live    = (biu_ext > CMP_W'(MAX_BITS)) ? CMP_W'(MAX_BITS) : biu_ext;

    // bit position of the head word
    assign base      = CMP_W'(word_cnt_reg) << WORD_BITS;
    assign last_word = (word_cnt_reg == CNT_W'(NCELL - 1));

    // set range stops at the end of the live bits
    assign set_sum = CMP_W'(req_data.index) + CMP_W'(req_data.count);
    assign set_hi  = (set_sum > live) ? live : set_sum;

    assign unit_ctrl.wr_en      = (state_reg == ST_WRITE) && wr_en_reg;
    assign unit_ctrl.wr_value   = value_reg;
    assign unit_ctrl.scan_value = value_reg;

    bra_word_unit #(
        .CMP_W (CMP_W)
    ) u_word_unit (
        .word_in   (head_word),
        .base      (base),
        .live      (live),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .run_in    (run_reg),
        .len       (len_reg),
        .ctrl      (unit_ctrl),
        .word_out  (unit_word),
        .run_out   (run_out),
        .hit       (unit_hit),
        .hit_start (hit_start)
    );

    // a zero-length allocate never finds a run
    assign scan_hit  = unit_hit && (len_reg != '0);
    assign found_now = found_reg || scan_hit;
    assign start_now = found_reg ? start_reg : hit_start;

    // tested bit sits in the head word
    assign test_here = test_ok_reg && ((lo_reg >> WORD_BITS) == CMP_W'(word_cnt_reg));

    // result register free or being drained this cycle
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            word_cnt_reg    <= '0;
            rsp_valid_reg   <= 1'b0;
            bits_in_use_reg <= BITS_IN_USE_RST;
        end
        else
        begin
            if (cfg_we)
                bits_in_use_reg <= cfg_wdata;
            // a result loaded this cycle keeps the valid flag set
            if (rsp_valid_reg && !rsp_stall && (state_reg != ST_DONE))
                rsp_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        word_cnt_reg <= '0;
                        op_reg       <= req_data.req_type;
                        value_reg    <= req_data.bit_value;
                        found_reg    <= 1'b0;
                        run_reg      <= '0;
                        len_reg      <= CMP_W'(req_data.count);
                        res_reg      <= '0;
                        case (req_data.req_type)
                            REQ_ALLOC:
                            begin
                                wr_en_reg   <= 1'b0;
                                test_ok_reg <= 1'b0;
                                state_reg   <= ST_SCAN;
                            end
                            REQ_SET:
                            begin
                                lo_reg      <= CMP_W'(req_data.index);
                                hi_reg      <= set_hi;
                                wr_en_reg   <= 1'b1;
                                test_ok_reg <= 1'b0;
                                state_reg   <= ST_WRITE;
                            end
                            REQ_TEST:
                            begin
                                lo_reg      <= CMP_W'(req_data.index);
                                hi_reg      <= '0;
                                wr_en_reg   <= 1'b0;
                                test_ok_reg <= CMP_W'(req_data.index) < CMP_W'(MAX_BITS);
                                state_reg   <= ST_WRITE;
                            end
                            default:
                            begin
                                // fill covers every stored bit, live or not
                                lo_reg      <= '0;
                                hi_reg      <= CMP_W'(NCELL * WORD_W);
                                wr_en_reg   <= 1'b1;
                                test_ok_reg <= 1'b0;
                                state_reg   <= ST_WRITE;
                            end
                        endcase
                    end
                end

                ST_SCAN:
                begin
                    run_reg <= run_out;
                    if (!found_reg && scan_hit)
                    begin
                        found_reg <= 1'b1;
                        start_reg <= hit_start;
                    end
                    if (last_word)
                    begin
                        word_cnt_reg <= '0;
                        if (found_now)
                        begin
                            // second pass flips the run
                            lo_reg               <= start_now;
                            hi_reg               <= start_now + len_reg;
                            value_reg            <= ~value_reg;
                            wr_en_reg            <= 1'b1;
                            res_reg.start_index  <= start_now[INDEX_W-1:0];
                            state_reg            <= ST_WRITE;
                        end
                        else
                        begin
                            res_reg.status <= STATUS_NO_RUN;
                            state_reg      <= ST_DONE;
                        end
                    end
                    else
                    begin
                        word_cnt_reg <= word_cnt_reg + CNT_W'(1);
                    end
                end

                ST_WRITE:
                begin
                    if (test_here)
                        res_reg.bit_read <= head_word[lo_reg[WORD_BITS-1:0]];
                    if (last_word)
                    begin
                        word_cnt_reg <= '0;
                        state_reg    <= ST_DONE;
                    end
                    else
                    begin
                        word_cnt_reg <= word_cnt_reg + CNT_W'(1);
                    end
                end

                ST_DONE:
                begin
                    if (out_free)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // take a new request only with the ring parked
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // ring is back in place whenever the sequencer waits
    `BRA_ASSERT_NOW(a_ring_parked, state_reg == ST_IDLE, word_cnt_reg == '0, "ring not parked in idle")
    // an accepted request always starts a pass
    `BRA_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, shift_en, "request did not start a pass")
    // only an allocate can report a missing run
    `BRA_ASSERT_NOW(a_no_run_alloc, state_reg == ST_DONE && res_reg.status == STATUS_NO_RUN, op_reg == REQ_ALLOC, "no-run status on a non-allocate request")

endmodule

// ----- tb/tb_bitmap_run_allocator_core.sv -----
// self-checking testbench for the bitmap run allocator core
`timescale 1ns / 1ps

module tb_bitmap_run_allocator_core;
    import bra_pkg::*;

    localparam int          HALF_PERIOD     = 5;
    localparam int          RESET_CYCLES    = 8;
    // allocate with a run found is the slowest request: two ring passes
    localparam int          DRAIN_CYCLES    = 2 * ((MAX_BITS_DEF + WORD_W - 1) / WORD_W) + 20;
    localparam int unsigned CYCLE_LIMIT     = 1000000;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int          PHASES          = 10;
    localparam int          ITEMS_PER_PHASE = 110;

    // live bit counts, one per phase: odd sizes, extremes, and values past the map
    localparam logic [COUNT_W-1:0] LIVE_PLAN [PHASES] = '{
        11'd37, 11'd1, 11'd2047, 11'd0, 11'd1025,
        11'd600, 11'd8, 11'd1024, 11'd513, 11'd100
    };

    // tracks the map as the block should hold it and the results it still owes
    class run_map_tracker;
        logic [MAX_BITS_DEF-1:0] map_bits;
        logic [COUNT_W-1:0]      live_reg;
        rsp_t                    owed_rsp[$];
        int unsigned             error_count;

        function new();
            map_bits    = '0;
            live_reg    = BITS_IN_USE_RST;
            error_count = 0;
        endfunction

        function int unsigned live_count();
            return (live_reg > MAX_BITS_DEF) ? MAX_BITS_DEF : live_reg;
        endfunction

        function void write_live(logic [COUNT_W-1:0] value);
            live_reg = value;
        endfunction

        // write stops at the last live bit
        function void write_span(int unsigned from, int unsigned len, logic value);
            int unsigned n;
            n = live_count();
            for (int unsigned i = 0; i < len && from < n; i++, from++)
                map_bits[from] = value;
        endfunction

        function void note_request(req_t r);
            rsp_t        exp;
            int unsigned n;
            int unsigned run;
            int unsigned len;
            int unsigned s;
            int unsigned first;
            bit          found;
            exp   = '0;
            found = 1'b0;
            first = 0;
            case (r.req_type)
                REQ_ALLOC:
                begin
                    n   = live_count();
                    len = r.count;
                    run = 0;
                    if (len != 0 && len <= n)
                    begin
                        for (s = 0; s < n && !found; s++)
                        begin
                            if (map_bits[s] == r.bit_value)
                            begin
                                run++;
                                if (run == len)
                                begin
                                    found = 1'b1;
                                    first = s + 1 - len;
                                end
                            end
                            else
                                run = 0;
                        end
                    end
                    if (found)
                    begin
                        write_span(first, len, ~r.bit_value);
                        exp.start_index = INDEX_W'(first);
                    end
                    else
                        exp.status = STATUS_NO_RUN;
                end
                REQ_SET:
                    write_span(r.index, r.count, r.bit_value);
                REQ_TEST:
                    exp.bit_read = map_bits[r.index];
                default:
                    map_bits = {MAX_BITS_DEF{r.bit_value}};
            endcase
            owed_rsp.push_back(exp);
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp;
            if (owed_rsp.size() == 0)
            begin
                $display("%0t: result with no request outstanding, actual %b/%0d/%b",
                         $time, got.status, got.start_index, got.bit_read);
                error_count++;
                return;
            end
            exp = owed_rsp.pop_front();
            if (got.status !== exp.status)
            begin
                $display("%0t: status mismatch, expected %b, actual %b",
                         $time, exp.status, got.status);
                error_count++;
            end
            if (got.start_index !== exp.start_index)
            begin
                $display("%0t: start_index mismatch, expected %0d, actual %0d",
                         $time, exp.start_index, got.start_index);
                error_count++;
            end
            if (got.bit_read !== exp.bit_read)
            begin
                $display("%0t: bit_read mismatch, expected %b, actual %b",
                         $time, exp.bit_read, got.bit_read);
                error_count++;
            end
        endfunction
    endclass

    // every block input starts at a known value
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    req_t               req_data  = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b1;
    rsp_t               rsp_data;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = BITS_IN_USE_RST;

    run_map_tracker sb = new();

    // stretch with no idling on either side
    bit          no_idle     = 1'b0;
    // bumped by the stimulus to ask the receiver for one long hold-off
    int unsigned hold_token  = 0;
    int unsigned hold_seen   = 0;
    int unsigned rx_left     = 0;
    bit          rx_stalling = 1'b1;
    int unsigned cycle_count = 0;

    bitmap_run_allocator_core #(
        .MAX_BITS (MAX_BITS_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // run limit, well above the slowest legal run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // gap length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // result side: check each accepted result, then pick the next stall pattern
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
        if (hold_token != hold_seen)
        begin
            // long hold-off so the block fills up and stalls new requests
            hold_seen   = hold_token;
            rx_stalling = 1'b1;
            rx_left     = HOLD_CYCLES;
        end
        else if (rx_left != 0)
            rx_left--;
        else if (no_idle || rx_stalling)
        begin
            rx_stalling = 1'b0;
            rx_left     = $urandom_range(0, 20);
        end
        else
        begin
            rx_stalling = 1'b1;
            rx_left     = pick_gap();
        end
        rsp_stall <= rx_stalling;
    end

    function automatic req_t make_req(logic [TYPE_W-1:0] kind, int unsigned idx,
                                      int unsigned cnt, logic value);
        req_t r;
        r.req_type  = kind;
        r.index     = INDEX_W'(idx);
        r.count     = COUNT_W'(cnt);
        r.bit_value = value;
        return r;
    endfunction

    // random request shaped around the live size so runs are found and missed
    function automatic req_t random_request(int unsigned live);
        req_t        r;
        int unsigned roll;
        int unsigned top;
        int unsigned near;
        top  = (live == 0) ? 0 : live - 1;
        near = live + $urandom_range(0, 2);
        near = (near == 0) ? 0 : near - 1;
        roll = $urandom_range(0, 99);
        // fill is kept rare so the map stays mixed
        if (roll < 42)
            r.req_type = REQ_ALLOC;
        else if (roll < 70)
            r.req_type = REQ_SET;
        else if (roll < 96)
            r.req_type = REQ_TEST;
        else
            r.req_type = REQ_FILL;
        r.bit_value = 1'($urandom_range(0, 1));
        roll = $urandom_range(0, 99);
        if (roll < 45)
            r.index = INDEX_W'($urandom_range(0, top));
        else if (roll < 80)
            r.index = INDEX_W'($urandom_range(0, 1023));
        else
            r.index = INDEX_W'((near > 1023) ? 1023 : near);
        roll = $urandom_range(0, 99);
        if (roll < 65)
            r.count = COUNT_W'($urandom_range(1, 8));
        else if (roll < 85)
            r.count = COUNT_W'($urandom_range(1, 64));
        else if (roll < 93)
            r.count = COUNT_W'($urandom_range(0, 2047));
        else
            r.count = COUNT_W'(near);
        return r;
    endfunction

    // offer one request after a random gap and hold it until accepted
    task automatic send_request(req_t r);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
    endtask

    // sender pauses until every owed result is back
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (sb.owed_rsp.size() != 0)
            @(posedge clk);
    endtask

    // only called with the block idle
    task automatic write_live(logic [COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.write_live(value);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned n;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests with the reset live count of 1024
        send_request(make_req(REQ_TEST, 0, 0, 1'b0));       // cleared map reads zero
        send_request(make_req(REQ_ALLOC, 0, 0, 1'b0));      // zero-length run, no run
        send_request(make_req(REQ_ALLOC, 0, 1, 1'b0));      // lowest free bit
        send_request(make_req(REQ_ALLOC, 0, 1024, 1'b0));   // whole map, broken by bit 0
        send_request(make_req(REQ_ALLOC, 0, 2047, 1'b1));   // longer than the live bits
        send_request(make_req(REQ_FILL, 0, 0, 1'b1));
        send_request(make_req(REQ_ALLOC, 0, 1024, 1'b1));   // whole map flips to zero
        send_request(make_req(REQ_SET, 1000, 2047, 1'b1));  // clipped at the top
        send_request(make_req(REQ_TEST, 1023, 0, 1'b0));
        send_request(make_req(REQ_ALLOC, 0, 23, 1'b1));     // run at the top end
        send_request(make_req(REQ_SET, 0, 0, 1'b1));        // zero-length set
        send_request(make_req(REQ_TEST, 0, 0, 1'b0));
        send_request(make_req(REQ_SET, 5, 3, 1'b1));
        send_request(make_req(REQ_ALLOC, 0, 6, 1'b0));      // skips the short gap below 5
        send_request(make_req(REQ_ALLOC, 0, 1, 1'b1));
        send_request(make_req(REQ_TEST, 6, 0, 1'b0));
        send_request(make_req(REQ_FILL, 0, 0, 1'b0));
        wait_for_results();

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_live(LIVE_PLAN[phase]);
            no_idle = (phase % 4 == 2);
            if (phase == 0)
            begin
                // live count of 37: clipping, bits past the live range
                send_request(make_req(REQ_SET, 30, 20, 1'b1));   // stops at bit 36
                send_request(make_req(REQ_TEST, 40, 0, 1'b0));   // stored, not live
                send_request(make_req(REQ_TEST, 36, 0, 1'b0));
                send_request(make_req(REQ_SET, 37, 5, 1'b1));    // start past live, no write
                send_request(make_req(REQ_ALLOC, 0, 38, 1'b0));  // longer than live
                send_request(make_req(REQ_ALLOC, 0, 7, 1'b1));
                send_request(make_req(REQ_FILL, 0, 0, 1'b1));    // reaches dead bits too
                send_request(make_req(REQ_TEST, 1023, 0, 1'b0));
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // receiver holds off while requests keep coming
                if (phase == 5 && n == 20)
                    hold_token++;
                // sender drains the block mid-phase
                if (phase == 7 && n == 60)
                    wait_for_results();
                send_request(random_request(sb.live_count()));
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.error_count == 0 && sb.owed_rsp.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
